### rtl/paged_slot_free_list_allocator_top_defines.svh
// Assertion macros for the paged slot allocator.
// Included by files that carry concurrent checks; expects clk and rst in scope.
`ifndef PAGED_SLOT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define PAGED_SLOT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTH
// Check on every clock edge outside reset.
`define PSFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every clock edge, reset included.
`define PSFL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSFL_ASSERT(lbl, prop, msg)
`define PSFL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/psfl_pkg.sv
// Shared types and constants of the paged slot allocator.
// No dependencies; imported by the top level and the page picker.
package psfl_pkg;

  localparam int NUM_PAGES      = 16;
  localparam int SLOTS_PER_PAGE = 128;

  localparam int PAGE_W   = $clog2(NUM_PAGES);
  localparam int SLOT_W   = $clog2(SLOTS_PER_PAGE);
  localparam int LINK_W   = SLOT_W + 1;            // slot index or terminal
  localparam int ADDR_W   = PAGE_W + SLOT_W;       // link memory address {page, slot}
  localparam int LINK_DEPTH = NUM_PAGES * SLOTS_PER_PAGE;
  localparam int PMADE_W  = $clog2(NUM_PAGES + 1);
  localparam int LIMIT_W  = 5;
  localparam int CMP_W    = (LIMIT_W > PMADE_W) ? LIMIT_W : PMADE_W;
  localparam int CNT_W    = 16;
  localparam int LIVE_W   = 12;
  localparam int STATUS_W = 2;

  localparam logic [LINK_W-1:0]  LINK_TERM   = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [PAGE_W-1:0] free_page;
    logic [SLOT_W-1:0] free_slot;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   got_page;
    logic [SLOT_W-1:0]   got_slot;
    logic [LIVE_W-1:0]   live_count;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [LINK_W-1:0] head;
  } page_rec_t;

  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] page;
  } pick_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_HEAD,
    S_PAGE,
    S_LINK,
    S_COMMIT
  } state_t;

endpackage

### rtl/paged_slot_free_list_allocator_top.sv
// Paged slot allocator: top level with page-state RAM, link RAM and sequencer.
// Depends on psfl_pkg, psfl_ram, psfl_pick and the assertion macro header.
`include "paged_slot_free_list_allocator_top_defines.svh"

// One item at a time. Alloc from an existing page: page read, link read, commit;
// alloc that makes a page: link RAM threading sweep (one entry a cycle), head
// read, link read, commit; free: page read, commit; refused item: commit. The
// result beat shows on rsp the cycle after its load; RAM reads set the rate.
// Reset (rst, synchronous) clears control, page count, live count and the
// nonempty map; RAM contents are not cleared, since only created pages are read.
module paged_slot_free_list_allocator_top import psfl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data
);

  // Control state
  state_t               state, state_next;
  logic [LIMIT_W-1:0]   page_limit;
  logic [PMADE_W-1:0]   pages_made;
  logic [LIVE_W-1:0]    live_slots, live_next;
  logic [NUM_PAGES-1:0] free_map;        // created page with a usable list head

  // Per-item working registers
  logic                 op_cmd;
  logic [PAGE_W-1:0]    op_page;
  logic [SLOT_W-1:0]    op_slot;
  logic [STATUS_W-1:0]  op_status;
  logic [SLOT_W-1:0]    sweep_idx;
  logic [CNT_W-1:0]     cur_count;
  logic [LINK_W-1:0]    cur_head;
  logic [LINK_W-1:0]    cur_link;

  // RAM ports
  logic                 page_we, page_re;
  logic [PAGE_W-1:0]    page_raddr;
  page_rec_t            page_wdata, page_rdata;
  logic                 link_we, link_re;
  logic [ADDR_W-1:0]    link_waddr, link_raddr;
  logic [LINK_W-1:0]    link_wdata, link_rdata;

  pick_t                pick;
  logic                 accept, rsp_free, commit, commit_ok;
  logic                 bad_free, can_make, sweep_last, new_free;
  logic [CMP_W-1:0]     limit_ext, eff_limit;
  page_rec_t            new_rec;
  logic [LINK_W-1:0]    sweep_link;

  psfl_pick u_pick (
    .free_map (free_map),
    .pick     (pick)
  );

  psfl_ram #(
    .WIDTH ($bits(page_rec_t)),
    .DEPTH (NUM_PAGES)
  ) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (op_page),
    .wdata (page_wdata),
    .re    (page_re),
    .raddr (page_raddr),
    .rdata (page_rdata)
  );

  psfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // Decisions taken on the accepted beat
  assign accept     = req_valid && !req_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign limit_ext  = CMP_W'(page_limit);
  assign eff_limit  = (limit_ext > CMP_W'(NUM_PAGES)) ? CMP_W'(NUM_PAGES) : limit_ext;
  assign can_make   = CMP_W'(pages_made) < eff_limit;
  // A 7-bit slot index is always inside a page, so only the page is checked.
  assign bad_free   = PMADE_W'(req.free_page) >= pages_made;
  assign sweep_last = sweep_idx == SLOT_W'(SLOTS_PER_PAGE - 1);
  assign sweep_link = sweep_last ? LINK_TERM : LINK_W'(sweep_idx) + LINK_W'(1);

  assign commit    = (state == S_COMMIT) && rsp_free;
  assign commit_ok = commit && (op_status == STATUS_OK);

  // Pop takes the link of the head; push links the freed slot to the old head.
  always_comb begin
    if (op_cmd == CMD_ALLOC) begin
      new_rec.count = cur_count - CNT_W'(1);
      new_rec.head  = cur_link;
      live_next     = live_slots + LIVE_W'(1);
    end else begin
      new_rec.count = cur_count + CNT_W'(1);
      new_rec.head  = LINK_W'(op_slot);
      live_next     = live_slots - LIVE_W'(1);
    end
    if (op_status != STATUS_OK) begin
      live_next = live_slots;
    end
    new_free = (new_rec.count != '0) && (new_rec.head < LINK_W'(SLOTS_PER_PAGE));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.cmd == CMD_ALLOC) begin
            if (pick.found) begin
              state_next = S_PAGE;
            end else if (can_make) begin
              state_next = S_SWEEP;
            end else begin
              state_next = S_COMMIT;
            end
          end else if (bad_free) begin
            state_next = S_COMMIT;
          end else begin
            state_next = S_PAGE;
          end
        end
      end
      S_SWEEP: begin
        if (sweep_last) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD:   state_next = S_LINK;
      S_PAGE:   state_next = (op_cmd == CMD_ALLOC) ? S_LINK : S_COMMIT;
      S_LINK:   state_next = S_COMMIT;
      S_COMMIT: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // RAM control and handshake outputs
  always_comb begin
    req_stall  = 1'b1;
    page_re    = 1'b0;
    page_raddr = (req.cmd == CMD_ALLOC) ? pick.page : req.free_page;
    page_we    = 1'b0;
    page_wdata = new_rec;
    link_re    = 1'b0;
    link_raddr = {op_page, page_rdata.head[SLOT_W-1:0]};
    link_we    = 1'b0;
    link_waddr = {op_page, op_slot};
    link_wdata = cur_head;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        page_re   = accept;
      end
      S_SWEEP: begin
        // Thread the new page: each slot links to the next, the last to terminal.
        link_we    = 1'b1;
        link_waddr = {op_page, sweep_idx};
        link_wdata = sweep_link;
      end
      S_HEAD: begin
        link_re    = 1'b1;
        link_raddr = {op_page, cur_head[SLOT_W-1:0]};
      end
      S_PAGE: begin
        link_re = (op_cmd == CMD_ALLOC);
      end
      S_LINK: begin
      end
      S_COMMIT: begin
        page_we = commit_ok;
        link_we = commit_ok && (op_cmd == CMD_FREE);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      page_limit <= LIMIT_RESET;
      pages_made <= '0;
      live_slots <= '0;
      free_map   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        page_limit <= cfg_data;
      end
      if ((state == S_SWEEP) && sweep_last) begin
        pages_made <= pages_made + PMADE_W'(1);
      end
      if (commit_ok) begin
        live_slots        <= live_next;
        free_map[op_page] <= new_free;
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd    <= req.cmd;
      op_slot   <= req.free_slot;
      sweep_idx <= '0;
      if (req.cmd == CMD_ALLOC) begin
        op_page   <= pick.found ? pick.page : pages_made[PAGE_W-1:0];
        op_status <= (pick.found || can_make) ? STATUS_OK : STATUS_FULL;
      end else begin
        op_page   <= req.free_page;
        op_status <= bad_free ? STATUS_BAD_FREE : STATUS_OK;
      end
    end
    if (state == S_SWEEP) begin
      sweep_idx <= sweep_idx + SLOT_W'(1);
      if (sweep_last) begin
        cur_count <= CNT_W'(SLOTS_PER_PAGE);
        cur_head  <= '0;
      end
    end
    if (state == S_PAGE) begin
      cur_count <= page_rdata.count;
      cur_head  <= page_rdata.head;
    end
    if (state == S_LINK) begin
      cur_link <= link_rdata;
    end
    if (commit) begin
      rsp.status     <= op_status;
      rsp.live_count <= live_next;
      if ((op_cmd == CMD_ALLOC) && (op_status == STATUS_OK)) begin
        rsp.got_page <= op_page;
        rsp.got_slot <= cur_head[SLOT_W-1:0];
      end else begin
        rsp.got_page <= '0;
        rsp.got_slot <= '0;
      end
    end
  end

  // Checks
  `PSFL_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE) && !rsp_valid, "reset not idle")
  `PSFL_ASSERT(a_accept_holds, accept |=> req_stall, "second beat taken while busy")
  `PSFL_ASSERT(a_pop_head_ok, (state == S_LINK) |-> (cur_head < LINK_W'(SLOTS_PER_PAGE)), "pop of terminal head")
  `PSFL_ASSERT(a_pages_step, (!$past(rst) && (pages_made != $past(pages_made))) |-> (pages_made == $past(pages_made) + PMADE_W'(1)), "page count jumped")
  `PSFL_ASSERT(a_pages_max, PMADE_W'(NUM_PAGES) >= pages_made, "too many pages")

endmodule

### rtl/psfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/psfl_pick.sv
// Page picker: newest created page whose free list is nonempty.
// Depends on psfl_pkg.
module psfl_pick import psfl_pkg::*; (
  input  logic [NUM_PAGES-1:0] free_map,
  output pick_t                pick
);

  always_comb begin
    pick = '0;
    // Ascending scan, so the highest set bit wins.
    for (int i = 0; i < NUM_PAGES; i++) begin
      if (free_map[i]) begin
        pick.found = 1'b1;
        pick.page  = PAGE_W'(i);
      end
    end
  end

endmodule
